// ===== rtl/hafs_pkg.sv =====
package hafs_pkg;

   localparam int ENTRIES_DEFAULT = 64;

   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 6;
   localparam int DESC_W   = 16;
   localparam int STATUS_W = 2;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_ALLOC   = 2'd0;
   localparam mode_type MODE_RELEASE = 2'd1;
   localparam mode_type MODE_LOOKUP  = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_BAD   = 2'd2;
   localparam status_type ST_FREED = 2'd3;

   typedef struct packed {
      logic push;
      logic pop;
   } stk_cmd_type;

endpackage

// ===== rtl/hafs_if.sv =====
interface hafs_req_if
   import hafs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [HANDLE_W-1:0] handle;
   logic [DESC_W-1:0]   descriptor;

   modport source (output valid, mode, handle, descriptor, input ready);
   modport sink   (input valid, mode, handle, descriptor, output ready);
endinterface

interface hafs_rsp_if
   import hafs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [HANDLE_W-1:0] result_handle;
   logic [DESC_W-1:0]   result_descriptor;

   modport source (output valid, status, result_handle, result_descriptor, input ready);
   modport sink   (input valid, status, result_handle, result_descriptor, output ready);
endinterface

// ===== rtl/hafs_ram.sv =====
module hafs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hafs_stack.sv =====
module hafs_stack
   import hafs_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int ID_W  = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  stk_cmd_type     cmd,
   input  logic [ID_W-1:0] push_id,
   output logic [ID_W-1:0] top,
   output logic            empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // the RAM is read every cycle at the slot that is on top after this cycle's
   // operation; a push in this cycle is served from the bypass register instead
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] top_slot;
   logic             bypass_ff;
   logic [ID_W-1:0]  bypass_id_ff;
   logic [ID_W-1:0]  ram_q;

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign top_slot = count_in - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         bypass_ff <= cmd.push;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         bypass_id_ff <= push_id;
      end
   end

   hafs_ram #(
      .WIDTH (ID_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (push_id),
      .rd_en   (1'b1),
      .rd_addr (top_slot[AW-1:0]),
      .rd_data (ram_q)
   );

   assign top   = bypass_ff ? bypass_id_ff : ram_q;
   assign empty = (count_ff == '0);

endmodule

// ===== rtl/handle_allocator_free_stack_core.sv =====
// Handle allocator: maps IDs to 16-bit descriptors. Allocate pops a released ID from the
// free stack, or hands out the next never-used ID, and stores the descriptor; release
// returns an in-use ID to the stack; lookup reads the descriptor back. One item is taken
// every clock. An item waits in the input register, where the table and the stack are
// updated, and its result is then presented from the result register; the registered read
// of the descriptor RAM is what calls for the result register. A full result side holds
// the input register and stalls the input. Table full, bad handle and already-released
// entries are reported in status and leave all state untouched. No clearing pass after
// reset: in-use bits are flops, and the read data of the descriptor and free stack RAMs
// is only used at written entries.
module handle_allocator_free_stack_core
   import hafs_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   hafs_req_if.sink   req_if,
   hafs_rsp_if.source rsp_if
);

   // only IDs below the handle range can ever be released or looked up
   localparam int LOCAL = (ENTRIES < (1 << HANDLE_W)) ? ENTRIES : (1 << HANDLE_W);
   localparam int IDX_W = $clog2(LOCAL);
   localparam int HW_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W = (HW_W > HANDLE_W) ? HW_W : HANDLE_W;

   // input stage
   logic                s1_valid_ff;
   mode_type            s1_mode_ff;
   logic [HANDLE_W-1:0] s1_handle_ff;
   logic [DESC_W-1:0]   s1_desc_ff;

   // result stage
   logic                s2_valid_ff;
   status_type          s2_status_ff;
   logic [HANDLE_W-1:0] s2_handle_ff;
   logic                s2_rd_sel_ff;

   logic [HW_W-1:0]     high_water_ff;
   logic [HW_W-1:0]     high_water_in;
   logic [LOCAL-1:0]    in_use_ff;
   logic [LOCAL-1:0]    in_use_in;

   logic                advance;
   logic                accept;
   logic                in_range;
   logic [IDX_W-1:0]    hidx;
   logic                hused;

   stk_cmd_type         stk_cmd;
   logic [IDX_W-1:0]    stk_top;
   logic                stk_empty;

   status_type          status;
   logic [HANDLE_W-1:0] rhandle;
   logic                rd_sel;
   logic                alloc_write;
   logic [IDX_W-1:0]    new_id;
   logic                lookup_read;
   logic                release_ok;
   logic [DESC_W-1:0]   ram_q;

   assign advance = s1_valid_ff && (!s2_valid_ff || rsp_if.ready);
   assign accept  = req_if.valid && req_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;

   assign in_range = CMP_W'(s1_handle_ff) < CMP_W'(high_water_ff);
   assign hidx     = s1_handle_ff[IDX_W-1:0];
   assign hused    = in_use_ff[hidx];

   always_comb begin
      status        = ST_OK;
      rhandle       = s1_handle_ff;
      rd_sel        = 1'b0;
      alloc_write   = 1'b0;
      new_id        = stk_top;
      lookup_read   = 1'b0;
      release_ok    = 1'b0;
      stk_cmd       = '0;
      high_water_in = high_water_ff;
      in_use_in     = in_use_ff;
      unique case (s1_mode_ff)
         MODE_ALLOC: begin
            if (!stk_empty) begin
               stk_cmd.pop = advance;
               alloc_write = 1'b1;
               rhandle     = HANDLE_W'(stk_top);
            end else if (high_water_ff < HW_W'(ENTRIES)) begin
               high_water_in = high_water_ff + HW_W'(1);
               new_id        = IDX_W'(high_water_ff);
               // IDs past the handle range are handed out but never stored
               alloc_write   = high_water_ff < HW_W'(LOCAL);
               rhandle       = HANDLE_W'(high_water_ff);
            end else begin
               status  = ST_FULL;
               rhandle = '0;
            end
            if (alloc_write) begin
               in_use_in[new_id] = 1'b1;
            end
         end
         MODE_RELEASE: begin
            if (!in_range) begin
               status = ST_BAD;
            end else if (!hused) begin
               status = ST_FREED;
            end else begin
               release_ok      = 1'b1;
               stk_cmd.push    = advance;
               in_use_in[hidx] = 1'b0;
            end
         end
         default: begin
            lookup_read = 1'b1;
            if (!in_range) begin
               status = ST_BAD;
            end else if (!hused) begin
               status = ST_FREED;
            end else begin
               rd_sel = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         high_water_ff <= '0;
         in_use_ff     <= '0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (advance) begin
            s2_valid_ff   <= 1'b1;
            high_water_ff <= high_water_in;
            in_use_ff     <= in_use_in;
         end else if (rsp_if.ready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff   <= req_if.mode;
         s1_handle_ff <= req_if.handle;
         s1_desc_ff   <= req_if.descriptor;
      end
      if (advance) begin
         s2_status_ff <= status;
         s2_handle_ff <= rhandle;
         s2_rd_sel_ff <= rd_sel;
      end
   end

   hafs_stack #(
      .DEPTH (LOCAL),
      .ID_W  (IDX_W)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd     (stk_cmd),
      .push_id (hidx),
      .top     (stk_top),
      .empty   (stk_empty)
   );

   hafs_ram #(
      .WIDTH (DESC_W),
      .DEPTH (LOCAL)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (advance && alloc_write),
      .wr_addr (new_id),
      .wr_data (s1_desc_ff),
      .rd_en   (advance && lookup_read),
      .rd_addr (hidx),
      .rd_data (ram_q)
   );

   assign rsp_if.valid             = s2_valid_ff;
   assign rsp_if.status            = s2_status_ff;
   assign rsp_if.result_handle     = s2_handle_ff;
   assign rsp_if.result_descriptor = s2_rd_sel_ff ? ram_q : '0;

   hw_bound_a: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= HW_W'(ENTRIES))
      else $error("high-water mark past table size");

   alloc_marks_a: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_mode_ff == MODE_ALLOC) && alloc_write |=> in_use_ff[$past(new_id)])
      else $error("allocated ID not marked in use");

   release_push_a: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_mode_ff == MODE_RELEASE) && release_ok
      |=> !stk_empty && !in_use_ff[$past(hidx)])
      else $error("released ID not on free stack");

   full_only_a: assert property (@(posedge clock) disable iff (reset)
      advance && (status == ST_FULL) |-> stk_empty && (high_water_ff == HW_W'(ENTRIES)))
      else $error("table full flagged with IDs available");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import hafs_pkg::*;

   localparam int SLOTS = ENTRIES_DEFAULT;
   // mode 3 has no name in the package; the block treats it as a lookup
   localparam mode_type MODE_SPARE = 2'd3;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [DESC_W-1:0]   desc;
   } reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hafs_req_if req_ch ();
   hafs_rsp_if rsp_ch ();

   handle_allocator_free_stack_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   // shadow of the handle table
   logic [DESC_W-1:0]   slot_desc [SLOTS];
   logic                slot_live [SLOTS];
   logic [HANDLE_W-1:0] spare_ids [SLOTS];
   int                  spare_count = 0;
   int                  next_fresh = 0;

   reply_t pending_replies [$];
   bit     quiet = 1'b0;
   int     items_sent = 0;
   int     replies_checked = 0;
   int     mismatches = 0;
   int     status_tally [4] = '{0, 0, 0, 0};
   int     mode_tally [4] = '{0, 0, 0, 0};

   function automatic reply_t table_step(mode_type m, logic [HANDLE_W-1:0] h,
                                         logic [DESC_W-1:0] d);
      reply_t r;
      int     id;
      bit     got;
      r.status = ST_OK;
      r.handle = h;
      r.desc = '0;
      got = 1'b0;
      id = 0;
      if (m == MODE_ALLOC) begin
         if (spare_count > 0) begin
            spare_count--;
            id = spare_ids[spare_count];
            got = 1'b1;
         end else if (next_fresh < SLOTS) begin
            id = next_fresh;
            next_fresh++;
            got = 1'b1;
         end
         if (got) begin
            slot_desc[id] = d;
            slot_live[id] = 1'b1;
            r.handle = HANDLE_W'(id);
         end else begin
            r.status = ST_FULL;
            r.handle = '0;
         end
      end else if (m == MODE_RELEASE) begin
         if (h >= next_fresh) begin
            r.status = ST_BAD;
         end else if (!slot_live[h]) begin
            r.status = ST_FREED;
         end else begin
            slot_live[h] = 1'b0;
            slot_desc[h] = '0;
            spare_ids[spare_count] = h;
            spare_count++;
         end
      end else begin
         if (h >= next_fresh) begin
            r.status = ST_BAD;
         end else if (!slot_live[h]) begin
            r.status = ST_FREED;
         end else begin
            r.desc = slot_desc[h];
         end
      end
      return r;
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_live_handle();
      logic [HANDLE_W-1:0] ids [$];
      for (int i = 0; i < next_fresh; i++)
         if (slot_live[i]) ids.push_back(HANDLE_W'(i));
      if (ids.size() == 0) return HANDLE_W'($urandom_range(0, SLOTS - 1));
      return ids[$urandom_range(0, ids.size() - 1)];
   endfunction

   // valid is left high on return so back-to-back items need no extra edge
   task automatic send_item(mode_type m, logic [HANDLE_W-1:0] h, logic [DESC_W-1:0] d);
      reply_t r;
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.handle <= h;
      req_ch.descriptor <= d;
      do @(posedge clock); while (!req_ch.ready);
      r = table_step(m, h, d);
      pending_replies.push_back(r);
      items_sent++;
      status_tally[r.status]++;
      mode_tally[m]++;
   endtask

   task automatic maybe_pause();
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_ops();
      send_item(MODE_LOOKUP, 6'd0, 16'h0000);       maybe_pause();
      send_item(MODE_RELEASE, 6'd63, 16'hFFFF);     maybe_pause();
      send_item(MODE_ALLOC, 6'd63, 16'h0000);       maybe_pause();
      send_item(MODE_ALLOC, 6'd0, 16'hFFFF);        maybe_pause();
      send_item(MODE_ALLOC, 6'd21, 16'hA5A5);       maybe_pause();
      send_item(MODE_LOOKUP, 6'd0, 16'hFFFF);       maybe_pause();
      send_item(MODE_LOOKUP, 6'd1, 16'h0000);       maybe_pause();
      send_item(MODE_SPARE, 6'd2, 16'h1234);        maybe_pause();
      send_item(MODE_LOOKUP, 6'd3, 16'h0000);       maybe_pause();
      send_item(MODE_RELEASE, 6'd1, 16'h0000);      maybe_pause();
      send_item(MODE_RELEASE, 6'd1, 16'h0000);      maybe_pause();
      send_item(MODE_LOOKUP, 6'd1, 16'h0000);       maybe_pause();
      send_item(MODE_RELEASE, 6'd0, 16'h0000);      maybe_pause();
      send_item(MODE_RELEASE, 6'd2, 16'h0000);      maybe_pause();
      // stack now holds 1, 0, 2: pops must come back newest first
      send_item(MODE_ALLOC, 6'd42, 16'h5A5A);       maybe_pause();
      send_item(MODE_ALLOC, 6'd0, 16'h1234);        maybe_pause();
      send_item(MODE_ALLOC, 6'd0, 16'hFFFF);        maybe_pause();
      send_item(MODE_ALLOC, 6'd0, 16'h0001);        maybe_pause();
      send_item(MODE_LOOKUP, 6'd3, 16'h0000);       maybe_pause();
      send_item(MODE_SPARE, 6'd2, 16'hFFFF);        maybe_pause();
      send_item(MODE_RELEASE, 6'd4, 16'h0000);      maybe_pause();
      send_item(MODE_RELEASE, 6'd63, 16'h0000);     maybe_pause();
      send_item(MODE_LOOKUP, 6'd63, 16'h0000);      maybe_pause();
   endtask

   task automatic test_fill_and_drain();
      while (next_fresh < SLOTS || spare_count > 0) begin
         send_item(MODE_ALLOC, HANDLE_W'($urandom()), DESC_W'($urandom()));
         maybe_pause();
      end
      repeat (2) begin
         send_item(MODE_ALLOC, HANDLE_W'($urandom()), DESC_W'($urandom()));
         maybe_pause();
      end
      drain_replies();
      repeat (4) begin
         send_item(MODE_LOOKUP, pick_live_handle(), DESC_W'($urandom()));
         maybe_pause();
      end
      while (spare_count < next_fresh) begin
         send_item(MODE_RELEASE, pick_live_handle(), DESC_W'($urandom()));
         maybe_pause();
      end
      send_item(MODE_RELEASE, HANDLE_W'($urandom()), 16'h0000);  maybe_pause();
      send_item(MODE_LOOKUP, HANDLE_W'($urandom()), 16'h0000);   maybe_pause();
      // refill entirely from the free stack, then hit full once more
      repeat (SLOTS + 1) begin
         send_item(MODE_ALLOC, HANDLE_W'($urandom()), DESC_W'($urandom()));
         maybe_pause();
      end
   endtask

   task automatic run_mixed_traffic(int count);
      int       alloc_pct;
      int       pick;
      mode_type m;
      alloc_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) alloc_pct = $urandom_range(15, 75);
         if (i % 400 == 399) drain_replies();
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) m = MODE_ALLOC;
         else if (pick < alloc_pct + (100 - alloc_pct) / 2) m = MODE_RELEASE;
         else m = ($urandom_range(0, 4) == 0) ? MODE_SPARE : MODE_LOOKUP;
         send_item(m, ($urandom_range(0, 3) != 0) ? pick_live_handle()
                                                   : HANDLE_W'($urandom_range(0, 63)),
                   DESC_W'($urandom()));
         maybe_pause();
      end
   endtask

   task automatic test_random_traffic();
      run_mixed_traffic(1150);
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      run_mixed_traffic(200);
   endtask

   // result side stalls in random bursts until the quiet phase
   always begin
      @(posedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      rsp_ch.ready <= 1'b1;
   end

   always @(posedge clock) begin
      reply_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         replies_checked++;
         if (pending_replies.size() == 0) begin
            if (mismatches < 10)
               $display("tb: unexpected reply status %0d handle %0d desc %h",
                        rsp_ch.status, rsp_ch.result_handle, rsp_ch.result_descriptor);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.result_handle !== want.handle ||
                rsp_ch.result_descriptor !== want.desc) begin
               if (mismatches < 10)
                  $display({"tb: reply %0d mismatch (expected/actual): status %0d/%0d",
                            " handle %0d/%0d desc %h/%h"},
                           replies_checked, want.status, rsp_ch.status, want.handle,
                           rsp_ch.result_handle, want.desc, rsp_ch.result_descriptor);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ALLOC;
      req_ch.handle = '0;
      req_ch.descriptor = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_desc[i] = '0;
         spare_ids[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_fill_and_drain();
      test_random_traffic();
      test_steady_stream();

      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_replies.size() != 0) mismatches++;

      $display("tb: %0d items (alloc %0d, release %0d, lookup %0d, mode 3 %0d), %0d replies",
               items_sent, mode_tally[MODE_ALLOC], mode_tally[MODE_RELEASE],
               mode_tally[MODE_LOOKUP], mode_tally[MODE_SPARE], replies_checked);
      $display("tb: status ok %0d, full %0d, bad handle %0d, released %0d; mismatches %0d",
               status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_BAD],
               status_tally[ST_FREED], mismatches);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: timeout with %0d replies outstanding", pending_replies.size());
      $display("tb: FAIL");
      $finish;
   end

endmodule
